// ===== design/rgb24_to_yuv420_converter_unit_assert.svh =====
// Assertion macros shared by the converter RTL.
`ifndef RGB24_TO_YUV420_CONVERTER_UNIT_ASSERT_SVH
`define RGB24_TO_YUV420_CONVERTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define R2Y_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define R2Y_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define R2Y_ASSERT_SAME(label, ante, cons)
`define R2Y_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== design/r2y420_pkg.sv =====
// Types and fixed constants of the RGB to YUV 4:2:0 converter.
package r2y420_pkg;

    typedef enum logic [1:0] {
        PLANE_Y = 2'd0,
        PLANE_U = 2'd1,
        PLANE_V = 2'd2
    } plane_t;

    localparam int unsigned CFG_DATA_W  = 13;
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned DIM_W       = 14;
    localparam int unsigned LUMA_IDX_W  = 24;
    localparam int unsigned CHROMA_IDX_W = 22;
    localparam int unsigned SUM_W       = 18;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_DATA_W-1:0] FRAME_DIM_RESET = 13'd256;
    localparam logic [DIM_W-1:0]      FRAME_DIM_MIN   = 14'd2;

    localparam logic signed [SUM_W-1:0] COEF_Y_R = 18'sd66;
    localparam logic signed [SUM_W-1:0] COEF_Y_G = 18'sd129;
    localparam logic signed [SUM_W-1:0] COEF_Y_B = 18'sd25;
    localparam logic signed [SUM_W-1:0] COEF_U_R = -18'sd38;
    localparam logic signed [SUM_W-1:0] COEF_U_G = -18'sd74;
    localparam logic signed [SUM_W-1:0] COEF_U_B = 18'sd112;
    localparam logic signed [SUM_W-1:0] COEF_V_R = 18'sd112;
    localparam logic signed [SUM_W-1:0] COEF_V_G = -18'sd94;
    localparam logic signed [SUM_W-1:0] COEF_V_B = -18'sd18;
    localparam logic signed [SUM_W-1:0] ROUND_ADD = 18'sd128;

    localparam logic [7:0] LUMA_OFFSET   = 8'd16;
    localparam logic [7:0] CHROMA_OFFSET = 8'd128;

endpackage

// ===== design/rgb24_to_yuv420_converter_unit.sv =====
// Top level of the RGB24 to YUV 4:2:0 converter with its pixel and sample channels.
//
//  Channel   Direction  Handshake                   Carries
//  pixel     in         in_valid / in_ready         red, green, blue
//  sample    out        out_valid / out_ready       plane, sample, plane_index, flags
//  config    in         cfg_write_en                cfg_index, cfg_data
//
// Each pixel passes the pixel register, then the single result register, which passes
// one sample per cycle unless out_ready stalls it; an odd-column pixel gives one sample, an even-column pixel two.
// A request is taken whenever the pixel register is empty or is releasing its last sample.
// Reset clears the counters, plane indices and valid flags, and loads 256 by 256.
// Back-pressure on the sample channel stalls the pixel register and then the input.
`include "rgb24_to_yuv420_converter_unit_assert.svh"

module rgb24_to_yuv420_converter_unit #(
    parameter int unsigned MAX_WIDTH  = 4096,
    parameter int unsigned MAX_HEIGHT = 4096
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic [7:0]                               red,
    input  logic [7:0]                               green,
    input  logic [7:0]                               blue,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output r2y420_pkg::plane_t                       plane,
    output logic [7:0]                               sample,
    output logic [r2y420_pkg::LUMA_IDX_W-1:0]        plane_index,
    output logic                                     last_of_pixel,
    output logic                                     frame_end,
    input  logic                                     cfg_write_en,
    input  logic [r2y420_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [r2y420_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import r2y420_pkg::*;

    localparam int unsigned COL_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned ROW_W = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
    localparam logic [DIM_W-1:0] WIDTH_MAX  = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);

    // Configuration registers.
    logic [CFG_DATA_W-1:0] frame_width_reg;
    logic [CFG_DATA_W-1:0] frame_height_reg;

    // Frame position and plane indices.
    logic [COL_W-1:0]        column_count_reg, column_count_next;
    logic [ROW_W-1:0]        row_count_reg, row_count_next;
    logic [LUMA_IDX_W-1:0]   luma_index_reg, luma_index_next;
    logic [CHROMA_IDX_W-1:0] u_index_reg, u_index_next;
    logic [CHROMA_IDX_W-1:0] v_index_reg, v_index_next;

    // Pixel register.
    logic                    item_valid_reg, item_valid_next;
    logic                    phase_reg, phase_next;
    logic [7:0]              red_reg, green_reg, blue_reg;
    logic [LUMA_IDX_W-1:0]   item_luma_idx_reg;
    logic [CHROMA_IDX_W-1:0] item_chroma_idx_reg;
    logic                    item_has_chroma_reg;
    plane_t                  item_chroma_plane_reg;
    logic                    item_fend_reg;

    // Result register.
    logic                    out_valid_reg, out_valid_next;
    plane_t                  out_plane_reg;
    logic [7:0]              out_sample_reg;
    logic [LUMA_IDX_W-1:0]   out_index_reg;
    logic                    out_last_reg;
    logic                    out_fend_reg;

    logic             accept;
    logic             out_load;
    logic             item_done;
    logic [DIM_W-1:0] width_clamped, height_clamped;
    logic [DIM_W-1:0] width_last, height_last;
    logic             row_end, fend_now, even_col, even_row;

    logic signed [SUM_W-1:0] r_ext, g_ext, b_ext;
    logic signed [SUM_W-1:0] y_sum, u_sum, v_sum;
    logic [7:0]              y_val, u_val, v_val;

    always_comb
    begin
        width_clamped = DIM_W'(frame_width_reg);
        if (width_clamped < FRAME_DIM_MIN)
        begin
            width_clamped = FRAME_DIM_MIN;
        end
        else if (width_clamped > WIDTH_MAX)
        begin
            width_clamped = WIDTH_MAX;
        end
        height_clamped = DIM_W'(frame_height_reg);
        if (height_clamped < FRAME_DIM_MIN)
        begin
            height_clamped = FRAME_DIM_MIN;
        end
        else if (height_clamped > HEIGHT_MAX)
        begin
            height_clamped = HEIGHT_MAX;
        end
    end

    assign width_last  = width_clamped - DIM_W'(1);
    assign height_last = height_clamped - DIM_W'(1);
    assign row_end     = DIM_W'(column_count_reg) >= width_last;
    assign fend_now    = row_end && (DIM_W'(row_count_reg) >= height_last);
    assign even_col    = ~column_count_reg[0];
    assign even_row    = ~row_count_reg[0];

    assign out_load  = item_valid_reg && (!out_valid_reg || out_ready);
    assign item_done = out_load && (phase_reg || !item_has_chroma_reg);
    assign in_ready  = !item_valid_reg || item_done;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        luma_index_next   = luma_index_reg;
        u_index_next      = u_index_reg;
        v_index_next      = v_index_reg;
        if (accept)
        begin
            luma_index_next = luma_index_reg + LUMA_IDX_W'(1);
            if (even_col && even_row)
            begin
                u_index_next = u_index_reg + CHROMA_IDX_W'(1);
            end
            if (even_col && !even_row)
            begin
                v_index_next = v_index_reg + CHROMA_IDX_W'(1);
            end
            if (fend_now)
            begin
                column_count_next = '0;
                row_count_next    = '0;
                luma_index_next   = '0;
                u_index_next      = '0;
                v_index_next      = '0;
            end
            else if (row_end)
            begin
                column_count_next = '0;
                row_count_next    = row_count_reg + ROW_W'(1);
            end
            else
            begin
                column_count_next = column_count_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        phase_next      = phase_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
            phase_next      = 1'b0;
        end
        else if (item_done)
        begin
            item_valid_next = 1'b0;
        end
        else if (out_load)
        begin
            phase_next = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Colour conversion; bits 15:8 of each sum give the floored shift modulo 256.
    assign r_ext = SUM_W'(red_reg);
    assign g_ext = SUM_W'(green_reg);
    assign b_ext = SUM_W'(blue_reg);
    assign y_sum = COEF_Y_R * r_ext + COEF_Y_G * g_ext + COEF_Y_B * b_ext + ROUND_ADD;
    assign u_sum = COEF_U_R * r_ext + COEF_U_G * g_ext + COEF_U_B * b_ext + ROUND_ADD;
    assign v_sum = COEF_V_R * r_ext + COEF_V_G * g_ext + COEF_V_B * b_ext + ROUND_ADD;
    assign y_val = y_sum[15:8] + LUMA_OFFSET;
    assign u_val = u_sum[15:8] + CHROMA_OFFSET;
    assign v_val = v_sum[15:8] + CHROMA_OFFSET;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_DIM_RESET;
            frame_height_reg <= FRAME_DIM_RESET;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            luma_index_reg   <= '0;
            u_index_reg      <= '0;
            v_index_reg      <= '0;
            item_valid_reg   <= 1'b0;
            phase_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default:          frame_width_reg  <= frame_width_reg;
                endcase
            end
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            luma_index_reg   <= luma_index_next;
            u_index_reg      <= u_index_next;
            v_index_reg      <= v_index_next;
            item_valid_reg   <= item_valid_next;
            phase_reg        <= phase_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            red_reg               <= red;
            green_reg             <= green;
            blue_reg              <= blue;
            item_luma_idx_reg     <= luma_index_reg;
            item_chroma_idx_reg   <= even_row ? u_index_reg : v_index_reg;
            item_has_chroma_reg   <= even_col;
            item_chroma_plane_reg <= even_row ? PLANE_U : PLANE_V;
            item_fend_reg         <= fend_now;
        end
        if (out_load)
        begin
            out_fend_reg <= item_fend_reg;
            if (phase_reg)
            begin
                out_plane_reg  <= item_chroma_plane_reg;
                out_sample_reg <= (item_chroma_plane_reg == PLANE_U) ? u_val : v_val;
                out_index_reg  <= LUMA_IDX_W'(item_chroma_idx_reg);
                out_last_reg   <= 1'b1;
            end
            else
            begin
                out_plane_reg  <= PLANE_Y;
                out_sample_reg <= y_val;
                out_index_reg  <= item_luma_idx_reg;
                out_last_reg   <= !item_has_chroma_reg;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign plane         = out_plane_reg;
    assign sample        = out_sample_reg;
    assign plane_index   = out_index_reg;
    assign last_of_pixel = out_last_reg;
    assign frame_end     = out_fend_reg;

    `R2Y_ASSERT_SAME(a_phase_needs_chroma, item_valid_reg && phase_reg, item_has_chroma_reg)
    `R2Y_ASSERT_NEXT(a_frame_end_clears, accept && fend_now,
        column_count_reg == '0 && row_count_reg == '0 && luma_index_reg == '0)
    `R2Y_ASSERT_NEXT(a_chroma_is_last, out_load && phase_reg,
        out_valid_reg && out_last_reg && out_plane_reg != PLANE_Y)
    `R2Y_ASSERT_NEXT(a_new_pixel_starts_luma, accept, item_valid_reg && !phase_reg)

endmodule
